// ===== hw/rtl/tmf_pkg.sv =====
// tabu move fifo package: move kind codes, request codes, tenure constants, match helper
`timescale 1ns / 1ps

package tmf_pkg;

  localparam int KIND_W   = 3;
  localparam int TENURE_W = 5;

  localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ZERO_ONE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ONE_ONE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ONE_TWO  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TWO_ONE  = 3'd4;

  localparam logic REQ_CHECK = 1'b0;
  localparam logic REQ_ADD   = 1'b1;

  localparam logic [TENURE_W-1:0] TENURE_RST = 5'd7;

  // number of leading indexes a kind compares, zero means it never matches
  function automatic logic [1:0] used_idx(input logic [KIND_W-1:0] kind);
    logic [1:0] n;
    case (kind) inside
      KIND_ZERO_ONE:               n = 2'd1;
      KIND_ONE_ONE:                n = 2'd2;
      KIND_ONE_TWO, KIND_TWO_ONE:  n = 2'd3;
      default:                     n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== hw/rtl/tmf_cell.sv =====
// one stage of the move chain: holds one stored move and compares it to the probe
`timescale 1ns / 1ps

module tmf_cell import tmf_pkg::*; #(
  parameter int INDEX_BITS = 16,
  parameter int CNT_W      = 5,
  parameter int POS        = 0
) (
  input  logic                  clk,
  input  logic                  shift_en,
  input  logic [KIND_W-1:0]     d_kind,
  input  logic [INDEX_BITS-1:0] d_a,
  input  logic [INDEX_BITS-1:0] d_b,
  input  logic [INDEX_BITS-1:0] d_c,
  input  logic [KIND_W-1:0]     p_kind,
  input  logic [INDEX_BITS-1:0] p_a,
  input  logic [INDEX_BITS-1:0] p_b,
  input  logic [INDEX_BITS-1:0] p_c,
  input  logic [CNT_W-1:0]      count,
  output logic [KIND_W-1:0]     q_kind,
  output logic [INDEX_BITS-1:0] q_a,
  output logic [INDEX_BITS-1:0] q_b,
  output logic [INDEX_BITS-1:0] q_c,
  output logic                  hit
);

  localparam logic [CNT_W-1:0] POS_C = CNT_W'(POS);

  logic [KIND_W-1:0]     kind_r;
  logic [INDEX_BITS-1:0] a_r;
  logic [INDEX_BITS-1:0] b_r;
  logic [INDEX_BITS-1:0] c_r;
  logic                  idx_eq;
  logic                  occupied;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      kind_r <= d_kind;
      a_r    <= d_a;
      b_r    <= d_b;
      c_r    <= d_c;
    end
  end

  always_comb begin
    unique case (used_idx(p_kind))
      2'd1:    idx_eq = (a_r == p_a);
      2'd2:    idx_eq = (a_r == p_a) && (b_r == p_b);
      2'd3:    idx_eq = (a_r == p_a) && (b_r == p_b) && (c_r == p_c);
      default: idx_eq = 1'b0;
    endcase
  end

  // cell k holds the k-th newest move, live only while k < occupancy
  assign occupied = (POS_C < count);
  assign hit      = occupied && (kind_r == p_kind) && idx_eq;

  assign q_kind = kind_r;
  assign q_a    = a_r;
  assign q_b    = b_r;
  assign q_c    = c_r;

endmodule

// ===== hw/rtl/tabu_move_fifo_membership.sv =====
// tabu move fifo: top level with the cell chain, occupancy and tenure control
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+-----------------------------
//   input   | in_req_type in_move_kind in_index_a/b/c | start while busy low
//   result  | out_is_tabu out_occupancy               | out_valid, one cycle strobe
//   config  | cfg_tenure                              | cfg_valid and cfg_ready
//
// one transaction per cycle: busy stays low and the result strobes the cycle after start.
// a check compares every cell of the chain in parallel; an add shifts the chain by one.
// the result is registered behind the parallel compare.
// rst_n is synchronous; it clears occupancy and restores tenure to seven.
// the receiver cannot stall, so results are never held back.
`timescale 1ns / 1ps

module tabu_move_fifo_membership import tmf_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int INDEX_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_req_type,
  input  logic [KIND_W-1:0]                 in_move_kind,
  input  logic [INDEX_BITS-1:0]             in_index_a,
  input  logic [INDEX_BITS-1:0]             in_index_b,
  input  logic [INDEX_BITS-1:0]             in_index_c,
  output logic                              out_valid,
  output logic                              out_is_tabu,
  output logic [$clog2(DEPTH+1)-1:0]        out_occupancy,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [TENURE_W-1:0]               cfg_tenure
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LW    = ((CNT_W > TENURE_W) ? CNT_W : TENURE_W) + 1;

  logic [TENURE_W-1:0]   tenure_r;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  out_valid_r;
  logic                  out_is_tabu_r;
  logic [CNT_W-1:0]      out_occupancy_r;

  logic                  accept;
  logic                  do_add;
  logic                  any_hit;
  logic [LW-1:0]         limit;
  logic [LW-1:0]         tenure_ext;
  logic [LW-1:0]         cnt_inc;

  logic [KIND_W-1:0]     kind_q [DEPTH];
  logic [INDEX_BITS-1:0] a_q    [DEPTH];
  logic [INDEX_BITS-1:0] b_q    [DEPTH];
  logic [INDEX_BITS-1:0] c_q    [DEPTH];
  logic [DEPTH-1:0]      hit_vec;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign do_add    = accept && (in_req_type == REQ_ADD);

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        tmf_cell #(.INDEX_BITS(INDEX_BITS), .CNT_W(CNT_W), .POS(gi)) u_cell (
          .clk      (clk),
          .shift_en (do_add),
          .d_kind   (in_move_kind),
          .d_a      (in_index_a),
          .d_b      (in_index_b),
          .d_c      (in_index_c),
          .p_kind   (in_move_kind),
          .p_a      (in_index_a),
          .p_b      (in_index_b),
          .p_c      (in_index_c),
          .count    (count_r),
          .q_kind   (kind_q[gi]),
          .q_a      (a_q[gi]),
          .q_b      (b_q[gi]),
          .q_c      (c_q[gi]),
          .hit      (hit_vec[gi])
        );
      end else begin : g_body
        tmf_cell #(.INDEX_BITS(INDEX_BITS), .CNT_W(CNT_W), .POS(gi)) u_cell (
          .clk      (clk),
          .shift_en (do_add),
          .d_kind   (kind_q[gi-1]),
          .d_a      (a_q[gi-1]),
          .d_b      (b_q[gi-1]),
          .d_c      (c_q[gi-1]),
          .p_kind   (in_move_kind),
          .p_a      (in_index_a),
          .p_b      (in_index_b),
          .p_c      (in_index_c),
          .count    (count_r),
          .q_kind   (kind_q[gi]),
          .q_a      (a_q[gi]),
          .q_b      (b_q[gi]),
          .q_c      (c_q[gi]),
          .hit      (hit_vec[gi])
        );
      end
    end
  endgenerate

  assign any_hit = |hit_vec;

  // effective tenure saturates at the chain length
  assign tenure_ext = LW'(tenure_r);
  assign limit      = (tenure_ext > LW'(DEPTH)) ? LW'(DEPTH) : tenure_ext;
  assign cnt_inc    = LW'(count_r) + LW'(1);

  // an add past the limit drops exactly one entry off the tail of the chain
  always_comb begin
    count_nxt = count_r;
    if (do_add) begin
      count_nxt = (cnt_inc > limit) ? count_r : CNT_W'(cnt_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tenure_r    <= TENURE_RST;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tenure_r <= cfg_tenure;
      end
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_is_tabu_r   <= (in_req_type == REQ_CHECK) && any_hit;
      out_occupancy_r <= count_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_is_tabu   = out_is_tabu_r;
  assign out_occupancy = out_occupancy_r;

endmodule

// ===== hw/rtl/tmf_checker.sv =====
// port level checks for the tabu move fifo, bound to the top level
`timescale 1ns / 1ps

module tmf_checker import tmf_pkg::*; #(
  parameter int DEPTH = 16
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       in_req_type,
  input logic [KIND_W-1:0]          in_move_kind,
  input logic                       out_valid,
  input logic                       out_is_tabu,
  input logic [$clog2(DEPTH+1)-1:0] out_occupancy
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic accept;
  assign accept = start && !busy;

  // every accepted transaction gives exactly one result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted transaction gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result without a transaction");

  a_add_not_tabu: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req_type == REQ_ADD)) |=> !out_is_tabu)
    else $error("add reported tabu");

  a_unknown_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req_type == REQ_CHECK) && (in_move_kind == KIND_UNKNOWN))
      |=> !out_is_tabu)
    else $error("unknown kind matched");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_occupancy <= CNT_W'(DEPTH)))
    else $error("occupancy beyond depth");

endmodule

bind tabu_move_fifo_membership tmf_checker #(.DEPTH(DEPTH)) u_tmf_checker (.*);
